>>> sv/ltcd_pkg.sv
package ltcd_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_ONGOING   = 2'd0,
		ST_COMPLETE  = 2'd1,
		ST_TRUNCATED = 2'd2,
		ST_BAD_KIND  = 2'd3
	} status_t;

	// Tile coding types
	localparam logic [2:0] KIND_RAW      = 3'd0;
	localparam logic [2:0] KIND_RLE      = 3'd1;
	localparam logic [2:0] KIND_TRI_R    = 3'd2;
	localparam logic [2:0] KIND_TRI_L    = 3'd3;
	localparam logic [2:0] KIND_TRAP_R   = 3'd4;
	localparam logic [2:0] KIND_TRAP_L   = 3'd5;
	localparam logic [2:0] KIND_LAST_OK  = 3'd5;

	localparam logic [4:0] ROW_TOP       = 5'd31;
	localparam logic [5:0] TILE_W        = 6'd32;
	localparam logic [7:0] SKIP_MIN      = 8'h80;

	// Pixels in a row for a given type; 32 for raw and run-length
	function automatic logic [5:0] row_len(input logic [2:0] kind, input logic [4:0] row);
		logic [5:0] half;
		logic [5:0] taper;
		logic [5:0] grow;
		logic [5:0] res;
		// lower half of the shape: 28,28,24,...,4,4 for rows 18..31
		half  = (6'd33 - {1'b0, row}) >> 1;
		taper = {half[3:0], 2'b00};
		// upper triangle: 0,4,4,8,...,28,28 for rows 0..14
		grow  = {2'b00, 4'((({1'b0, row} + 6'd1) >> 1))} << 2;
		res = TILE_W;
		if (kind == KIND_TRI_R || kind == KIND_TRI_L) begin
			if (row < 5'd15)
				res = grow;
			else if (row > 5'd17)
				res = taper;
		end else if (kind == KIND_TRAP_R || kind == KIND_TRAP_L) begin
			if (row > 5'd17)
				res = taper;
		end
		return res;
	endfunction

	// First column of a row
	function automatic logic [4:0] row_first(input logic [2:0] kind, input logic [4:0] row);
		logic [5:0] start;
		start = 6'd0;
		if (kind == KIND_TRI_R || kind == KIND_TRAP_R)
			start = TILE_W - row_len(kind, row);
		return start[4:0];
	endfunction

	// One past the last column of a row
	function automatic logic [5:0] row_end(input logic [2:0] kind, input logic [4:0] row);
		logic [5:0] stop;
		stop = row_len(kind, row);
		if (kind == KIND_TRI_R || kind == KIND_TRAP_R)
			stop = TILE_W;
		return stop;
	endfunction

endpackage

>>> sv/level_tile_cel_decoder_unit.sv
// Level tile decoder: turns the coded byte stream of one 32x32 level tile
// into pixel words, one data byte per input word.
// Input channel: data_byte with first_byte, last_byte and tile_kind, moved
// on in_valid with in_stall low. first_byte starts a tile (tile_kind is
// taken then) and abandons any tile in progress. Bytes with first_byte low
// while no tile is in progress are dropped.
// Output channel: pixel_valid, pixel_x, pixel_y, colour_index and status,
// moved on out_valid with out_stall low. A pixel byte always yields a word;
// a run-length control byte yields one only when it ends the tile.
// status: 0 ongoing, 1 tile complete, 2 truncated data, 3 invalid type.
// One output register holds the word; it appears in the cycle after its
// input word is taken. Throughput: one byte per cycle while the output
// is not stalled; position counters and row tables are combinational.
// When the receiver stalls with a word held, in_stall rises in the same
// cycle; a word is taken again in the cycle the held word leaves.
// Reset (arst_n low, asynchronous) empties the output register and leaves
// the decoder idle at row 31, column 0.
module level_tile_cel_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	input  logic [2:0] tile_kind,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       pixel_valid,
	output logic [4:0] pixel_x,
	output logic [4:0] pixel_y,
	output logic [7:0] colour_index,
	output logic [1:0] status
);

	// decoder state
	logic [2:0] kind_q;
	logic [4:0] col_q;
	logic [4:0] row_q;
	logic [6:0] run_q;
	logic       busy_q;

	// output register
	logic       out_valid_q;
	logic       pix_q;
	logic [4:0] px_q;
	logic [4:0] py_q;
	logic [7:0] colour_q;
	logic [1:0] status_q;

	logic       accept;

	// next-state and result
	logic [2:0] kind_d;
	logic [4:0] col_d;
	logic [4:0] row_d;
	logic [6:0] run_d;
	logic       busy_d;
	logic       emit;
	logic       pix;
	logic [1:0] st;

	logic [2:0] kind_e;
	logic [4:0] col_e;
	logic [4:0] row_e;
	logic [6:0] run_e;
	logic       busy_e;
	logic       done;
	logic [5:0] col_inc;
	logic [7:0] skip;
	logic [7:0] col_sum;
	logic [4:0] row_dn;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// effective state once first_byte is applied
	always_comb begin
		if (first_byte) begin
			kind_e = tile_kind;
			row_e  = ltcd_pkg::ROW_TOP;
			run_e  = 7'd0;
			col_e  = ltcd_pkg::row_first(tile_kind, ltcd_pkg::ROW_TOP);
			busy_e = 1'b1;
		end else begin
			kind_e = kind_q;
			row_e  = row_q;
			run_e  = run_q;
			col_e  = col_q;
			busy_e = busy_q;
		end
	end

	assign col_inc = {1'b0, col_e} + 6'd1;
	assign skip    = ~data_byte + 8'd1;
	assign col_sum = {3'b000, col_e} + skip;
	assign row_dn  = row_e - 5'd1;

	// per-byte decode
	always_comb begin
		kind_d = kind_e;
		col_d  = col_e;
		row_d  = row_e;
		run_d  = run_e;
		busy_d = busy_e;
		pix    = 1'b0;
		done   = 1'b0;
		emit   = 1'b0;
		st     = ltcd_pkg::ST_ONGOING;
		if (first_byte && tile_kind > ltcd_pkg::KIND_LAST_OK) begin
			busy_d = 1'b0;
			col_d  = 5'd0;
			emit   = 1'b1;
			st     = ltcd_pkg::ST_BAD_KIND;
		end else if (busy_e) begin
			if (kind_e == ltcd_pkg::KIND_RLE) begin
				if (run_e != 7'd0) begin
					// literal pixel of a run
					pix   = 1'b1;
					run_d = run_e - 7'd1;
					col_d = col_inc[4:0];
					if (col_inc[5]) begin
						col_d = 5'd0;
						if (row_e == 5'd0)
							done = 1'b1;
						else
							row_d = row_dn;
					end
				end else if (data_byte >= ltcd_pkg::SKIP_MIN) begin
					// transparent skip, wraps at most one row
					col_d = col_sum[4:0];
					if (col_sum[7:5] != 3'd0) begin
						col_d = 5'd0;
						if (row_e == 5'd0)
							done = 1'b1;
						else
							row_d = row_dn;
					end
				end else begin
					run_d = data_byte[6:0];
				end
			end else begin
				// fixed-shape types: every byte is a pixel
				pix   = 1'b1;
				col_d = col_inc[4:0];
				if (col_inc >= ltcd_pkg::row_end(kind_e, row_e)) begin
					if (row_e == 5'd0 || ltcd_pkg::row_len(kind_e, row_dn) == 6'd0) begin
						done = 1'b1;
					end else begin
						row_d = row_dn;
						col_d = ltcd_pkg::row_first(kind_e, row_dn);
					end
				end
			end
			if (done) begin
				busy_d = 1'b0;
				run_d  = 7'd0;
				st     = ltcd_pkg::ST_COMPLETE;
			end else if (last_byte) begin
				busy_d = 1'b0;
				st     = ltcd_pkg::ST_TRUNCATED;
			end
			emit = pix || (st != ltcd_pkg::ST_ONGOING);
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= 3'd0;
			col_q  <= 5'd0;
			row_q  <= ltcd_pkg::ROW_TOP;
			run_q  <= 7'd0;
			busy_q <= 1'b0;
		end else if (accept) begin
			kind_q <= kind_d;
			col_q  <= col_d;
			row_q  <= row_d;
			run_q  <= run_d;
			busy_q <= busy_d;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!in_stall)
			out_valid_q <= accept && emit;
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			pix_q    <= pix;
			px_q     <= pix ? col_e : 5'd0;
			py_q     <= pix ? row_e : 5'd0;
			colour_q <= pix ? data_byte : 8'd0;
			status_q <= st;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_valid  = pix_q;
	assign pixel_x      = px_q;
	assign pixel_y      = py_q;
	assign colour_index = colour_q;
	assign status       = status_q;

endmodule

>>> sv/ltcd_checker.sv
module ltcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       pixel_valid,
	input logic [4:0] pixel_x,
	input logic [4:0] pixel_y,
	input logic [7:0] colour_index,
	input logic [1:0] status
);

	// a held output word keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(colour_index) && $stable(status))
		else $error("held output word changed");

	// input only stalls behind a stalled output word
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held output word");

	// no output word appears without an input word
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) && !(in_valid && !in_stall) |=> !out_valid)
		else $error("output word without input word");

	// non-pixel words carry zero coordinates and colour, and a bad type no pixel
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> pixel_x == 5'd0 && pixel_y == 5'd0
			&& colour_index == 8'd0)
		else $error("non-pixel word carries pixel data");

	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ltcd_pkg::ST_BAD_KIND |-> !pixel_valid)
		else $error("invalid-type word carries a pixel");

endmodule

bind level_tile_cel_decoder_unit ltcd_checker u_ltcd_checker (.*);
